[src/assert_macros.svh]
// Assertion helpers for the cache tag unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[src/salc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative cache tag unit.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int MAX_SETS  = 256;
    localparam int MAX_WAYS  = 8;
    localparam int SET_W     = 8;
    localparam int WAY_W     = 3;
    localparam int TAG_W     = 32;
    localparam int LRU_W     = MAX_WAYS * WAY_W;

    localparam logic [1:0] FUNC_WRITE = 2'd1;

    localparam logic [1:0] CFG_OFFSET = 2'd0;
    localparam logic [1:0] CFG_INDEX  = 2'd1;
    localparam logic [1:0] CFG_WAYS   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOOKUP,
        ST_OUT
    } state_t;

    // Identity LRU order: way 0 is most recently used
    function automatic logic [LRU_W-1:0] lru_identity();
        logic [LRU_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            r[i*WAY_W +: WAY_W] = WAY_W'(i);
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

[src/set_assoc_lru_writeback_cache_tags_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_tags_unit
// Tag, valid, dirty and LRU store of a write-back, write-allocate cache.
// ----------------------------------------------------------------------------
// An access request reads the set row from the tag/state memory and the LRU
// memory as it is taken in ST_IDLE, compares, updates and writes the row back
// in ST_LOOKUP, and shows the result in ST_OUT. After reset a clearing pass
// runs over all 256 sets, one set per cycle, before the first request is
// taken. The result register frees as soon as it is taken downstream.
`include "assert_macros.svh"

module set_assoc_lru_writeback_cache_tags_unit
    import salc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address[31:0], func[33:32], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [135:0] m_tdata,  // hit, writeback, way_used[2:0], access_total,
                                   // hit_total, miss_total, writeback_total, pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int ROW_W = MAX_WAYS * (TAG_W + 2);

    // Row memories: per way {valid, dirty, tag}
    logic [ROW_W-1:0] row_mem [MAX_SETS];
    logic [LRU_W-1:0] lru_mem [MAX_SETS];
    logic [ROW_W-1:0] row_rd_reg;
    logic [LRU_W-1:0] lru_rd_reg;

    state_t state_reg, state_next;
    logic [SET_W:0] clr_reg, clr_next;
    logic [3:0] off_reg, idx_reg, ways_reg;
    logic [31:0] addr_reg;
    logic        wr_reg;
    logic [31:0] acc_reg, hit_cnt_reg, miss_reg, wb_cnt_reg;
    logic [31:0] acc_next, hit_cnt_next, miss_next, wb_cnt_next;
    logic        hit_reg, wbf_reg, hit_next, wbf_next;
    logic [WAY_W-1:0] way_reg, way_next;

    logic [SET_W-1:0] set_in, set_cur;
    logic [31:0] tag_cur;
    logic [3:0] ib, nw;
    logic        mem_we;
    logic [SET_W-1:0] mem_addr;
    logic [ROW_W-1:0] row_wr;
    logic [LRU_W-1:0] lru_wr;

    // Set index from a raw address
    function automatic logic [SET_W-1:0] set_of(input logic [31:0] a,
                                                input logic [3:0] o,
                                                input logic [3:0] i);
        logic [31:0] s;
        s = (a >> o) & ((32'd1 << i) - 32'd1);
        return s[SET_W-1:0];
    endfunction

    always_comb
    begin
        ib = (idx_reg > 4'(SET_W)) ? 4'(SET_W) : idx_reg;
        nw = (ways_reg == 4'd0) ? 4'd1 : ((ways_reg > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : ways_reg);
        set_in  = set_of(s_tdata[31:0], off_reg, ib);
        set_cur = set_of(addr_reg, off_reg, ib);
        tag_cur = 32'({1'b0, addr_reg} >> ({1'b0, off_reg} + {1'b0, ib}));
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg  <= 4'd6;
            idx_reg  <= 4'd8;
            ways_reg <= 4'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OFFSET: off_reg  <= cfg_data;
                CFG_INDEX:  idx_reg  <= cfg_data;
                CFG_WAYS:   ways_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Lookup, replacement choice and row update
    always_comb
    begin
        logic found, vb, db;
        logic [TAG_W-1:0] t;
        logic [WAY_W-1:0] w, victim;
        logic [LRU_W-1:0] ord;
        logic mv;
        state_next   = state_reg;
        clr_next     = clr_reg;
        acc_next     = acc_reg;
        hit_cnt_next = hit_cnt_reg;
        miss_next    = miss_reg;
        wb_cnt_next  = wb_cnt_reg;
        hit_next     = hit_reg;
        wbf_next     = wbf_reg;
        way_next     = way_reg;
        mem_we       = 1'b0;
        mem_addr     = set_in;
        row_wr       = row_rd_reg;
        lru_wr       = lru_rd_reg;
        found  = 1'b0;
        vb     = 1'b0;
        db     = 1'b0;
        t      = '0;
        w      = '0;
        victim = '0;
        ord    = lru_rd_reg;
        mv     = 1'b0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg[SET_W-1:0];
                row_wr   = '0;
                lru_wr   = lru_identity();
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (SET_W+1)'(MAX_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                mem_addr = set_cur;
                mem_we   = 1'b1;
                acc_next = sat_inc(acc_reg);
                wbf_next = 1'b0;
                w = '0;
                // Search for a hit
                for (int i = 0; i < MAX_WAYS; i++)
                begin
                    vb = row_rd_reg[i*(TAG_W+2) + TAG_W + 1];
                    t  = row_rd_reg[i*(TAG_W+2) +: TAG_W];
                    if (!found && (4'(i) < nw) && vb && (t == tag_cur))
                    begin
                        found = 1'b1;
                        w = WAY_W'(i);
                    end
                end
                hit_next = found;
                if (found)
                begin
                    hit_cnt_next = sat_inc(hit_cnt_reg);
                    if (wr_reg)
                    begin
                        row_wr[32'(w)*(TAG_W+2) + TAG_W] = 1'b1;
                    end
                end
                else
                begin
                    miss_next = sat_inc(miss_reg);
                    // Lowest invalid way
                    for (int i = 0; i < MAX_WAYS; i++)
                    begin
                        vb = row_rd_reg[i*(TAG_W+2) + TAG_W + 1];
                        if (!found && (4'(i) < nw) && !vb)
                        begin
                            found = 1'b1;
                            w = WAY_W'(i);
                        end
                    end
                    if (!found)
                    begin
                        // Least recent way that is in use
                        for (int p = 0; p < MAX_WAYS; p++)
                        begin
                            if ({1'b0, lru_rd_reg[p*WAY_W +: WAY_W]} < nw)
                            begin
                                victim = lru_rd_reg[p*WAY_W +: WAY_W];
                            end
                        end
                        w  = victim;
                        db = row_rd_reg[32'(w)*(TAG_W+2) + TAG_W];
                        if (db)
                        begin
                            wbf_next    = 1'b1;
                            wb_cnt_next = sat_inc(wb_cnt_reg);
                        end
                    end
                    row_wr[32'(w)*(TAG_W+2) +: (TAG_W+2)] = {1'b1, wr_reg, tag_cur};
                end
                way_next = w;
                // Move way to the front of the order
                for (int p = MAX_WAYS-1; p > 0; p--)
                begin
                    if (lru_rd_reg[p*WAY_W +: WAY_W] == w)
                    begin
                        mv = 1'b1;
                    end
                end
                mv = 1'b0;
                for (int p = 0; p < MAX_WAYS; p++)
                begin
                    if (lru_rd_reg[p*WAY_W +: WAY_W] == w)
                    begin
                        mv = 1'b1;
                    end
                    if (p > 0 && !mv)
                    begin
                        ord[p*WAY_W +: WAY_W] = lru_rd_reg[(p-1)*WAY_W +: WAY_W];
                    end
                    else if (p > 0 && lru_rd_reg[p*WAY_W +: WAY_W] == w)
                    begin
                        ord[p*WAY_W +: WAY_W] = lru_rd_reg[(p-1)*WAY_W +: WAY_W];
                    end
                end
                ord[WAY_W-1:0] = w;
                lru_wr = ord;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            acc_reg     <= '0;
            hit_cnt_reg <= '0;
            miss_reg    <= '0;
            wb_cnt_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            acc_reg     <= acc_next;
            hit_cnt_reg <= hit_cnt_next;
            miss_reg    <= miss_next;
            wb_cnt_reg  <= wb_cnt_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            addr_reg <= s_tdata[31:0];
            wr_reg   <= (s_tdata[33:32] == FUNC_WRITE);
        end
        hit_reg <= hit_next;
        wbf_reg <= wbf_next;
        way_reg <= way_next;
    end

    // Row memories, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_addr] <= row_wr;
            lru_mem[mem_addr] <= lru_wr;
        end
        row_rd_reg <= row_mem[mem_addr];
        lru_rd_reg <= lru_mem[mem_addr];
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {3'b0, wb_cnt_reg, miss_reg, hit_cnt_reg, acc_reg,
                       way_reg, wbf_reg, hit_reg};

    `ASSERT_IMPL(a_count_sum, 1'b1,
        (acc_reg == 32'hFFFF_FFFF) || (acc_reg == hit_cnt_reg + miss_reg),
        "access count differs from hits plus misses")
    `ASSERT_IMPL(a_wb_miss, m_tvalid && wbf_reg, !hit_reg,
        "writeback reported on a hit")
    `ASSERT_NEXT(a_lookup_out, state_reg == ST_LOOKUP, m_tvalid,
        "lookup not followed by result")

endmodule
